// ----- design/lvp_pkg.sv -----
// ----------------------------------------------------------------------------
// lvp_pkg
// Shared types and constants of the laser vector point generator.
// ----------------------------------------------------------------------------
package lvp_pkg;

  localparam int DEF_MAX_STEPS  = 16;
  localparam int DEF_MAX_DWELL  = 8;
  localparam int DEF_MAX_SETTLE = 24;
  localparam int DEF_COORD_BITS = 12;
  localparam int CMD_DEPTH      = 4;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_BLANK_SETTLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_DWELL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_DENSITY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_COSINE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y       = 3'd5;

  typedef struct packed {
    logic [11:0] vertex_x;
    logic [11:0] vertex_y;
    logic        first_vertex;
    logic        last_vertex;
    logic        closed_loop;
  } in_item_t;

  typedef struct packed {
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        beam_on;
    logic        run_end;
  } out_item_t;

  typedef struct packed {
    logic [4:0]         blank_settle;
    logic [3:0]         corner_dwell;
    logic [15:0]        point_density;
    logic signed [15:0] corner_cosine;
    logic [23:0]        scale_x;
    logic [23:0]        scale_y;
  } cfg_t;

  // One command for the point emitter: a run of repeated points, or the
  // interior points of a segment given as quotient/remainder per step.
  typedef struct packed {
    logic        seg;
    logic [15:0] x;
    logic [15:0] y;
    logic        on;
    logic        last;
    logic [6:0]  cnt;
    logic        neg_x;
    logic        neg_y;
    logic [15:0] qx;
    logic [15:0] qy;
    logic [4:0]  rx;
    logic [4:0]  ry;
    logic [4:0]  steps;
  } cmd_t;

endpackage

// ----- design/lvp_fifo.sv -----
// ----------------------------------------------------------------------------
// lvp_fifo
// Short command queue between the vertex sequencer and the point emitter.
// ----------------------------------------------------------------------------
module lvp_fifo
  import lvp_pkg::*;
#(
  parameter int DEPTH = CMD_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W:0]   cnt_r;

  assign full    = (cnt_r == (PTR_W+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == PTR_W'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == PTR_W'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PTR_W+1)'(wr_en) - (PTR_W+1)'(rd_en);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (!full || rd_en))
    else $error("command written into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("command read from empty queue");

endmodule

// ----- design/lvp_front.sv -----
// ----------------------------------------------------------------------------
// lvp_front
// Vertex sequencer: scales a vertex, walks the point operations it causes,
// works out corners and segment step counts, and queues emitter commands.
// ----------------------------------------------------------------------------
module lvp_front
  import lvp_pkg::*;
#(
  parameter int MAX_STEPS  = DEF_MAX_STEPS,
  parameter int MAX_DWELL  = DEF_MAX_DWELL,
  parameter int MAX_SETTLE = DEF_MAX_SETTLE,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  input  cfg_t     cfg,
  output logic     cmd_push,
  output cmd_t     cmd,
  input  logic     cmd_full
);

  localparam logic [11:0] CMASK = (COORD_BITS >= 12) ? 12'hFFF
                                                     : 12'((1 << COORD_BITS) - 1);

  typedef enum logic [20:0] {
    S_IDLE  = 21'd1 << 0,
    S_MX    = 21'd1 << 1,
    S_MY    = 21'd1 << 2,
    S_SY    = 21'd1 << 3,
    S_OP    = 21'd1 << 4,
    S_SQ1   = 21'd1 << 5,
    S_SQ2   = 21'd1 << 6,
    S_SQ3   = 21'd1 << 7,
    S_SQRT  = 21'd1 << 8,
    S_LEN   = 21'd1 << 9,
    S_D1    = 21'd1 << 10,
    S_D2    = 21'd1 << 11,
    S_D3    = 21'd1 << 12,
    S_D4    = 21'd1 << 13,
    S_D5    = 21'd1 << 14,
    S_D6    = 21'd1 << 15,
    S_ST1   = 21'd1 << 16,
    S_ST2   = 21'd1 << 17,
    S_DIV   = 21'd1 << 18,
    S_EMIT  = 21'd1 << 19,
    S_FLUSH = 21'd1 << 20
  } state_t;

  typedef enum logic [2:0] {OP_SKIP, OP_VTX, OP_SEG, OP_BLANK, OP_END} op_kind_t;
  typedef enum logic [2:0] {P_CUR, P_BEF, P_NEW, P_START, P_SEC} pt_sel_t;
  typedef enum logic [1:0] {VM_NONE, VM_ALW, VM_CORN} vmode_t;
  typedef enum logic [1:0] {SUB_SEG, SUB_CIN, SUB_COUT} sub_t;

  typedef struct packed {
    op_kind_t kind;
    pt_sel_t  a;
    pt_sel_t  p;
    pt_sel_t  n;
    vmode_t   vm;
    logic     settle;
  } op_t;

  function automatic logic [15:0] sat16(input logic signed [43:0] p);
    logic [38:0] v;
    v = p[38:0] + 39'd256;
    if (v[38:9] > 30'd65535) begin
      return 16'hFFFF;
    end
    return v[24:9];
  endfunction

  function automatic logic signed [16:0] dif(input logic [15:0] a, input logic [15:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic logic [15:0] mag(input logic signed [16:0] d);
    logic signed [16:0] m;
    m = d[16] ? -d : d;
    return m[15:0];
  endfunction

  function automatic cmd_t mk_rep(input logic [31:0] pt, input logic on,
                                  input logic [6:0] cnt);
    cmd_t c;
    c       = '0;
    c.x     = pt[31:16];
    c.y     = pt[15:0];
    c.on    = on;
    c.cnt   = cnt;
    return c;
  endfunction

  state_t             state_r;
  in_item_t           vin_r;
  logic [31:0]        new_r, cur_r, bef_r, start_r, sec_r;   // {x, y}
  logic [1:0]         seen_r;
  logic               loop_r;
  logic [2:0]         ph_r;
  sub_t               sub_r;
  logic signed [16:0] ix_r, iy_r, ox_r, oy_r;
  logic signed [43:0] prod_r;
  logic [33:0]        acc_r, rad_r;
  logic [20:0]        rem_r;
  logic [16:0]        root_r, il_r, pphi_r;
  logic signed [35:0] dot_r;
  logic signed [33:0] lo_r;
  logic [4:0]         steps_r, it_r;
  logic [15:0]        dnum_r, dq_r, qx_r;
  logic [4:0]         drem_r, rx_r;
  logic               dsel_r;
  cmd_t               newc_r, pend_r;
  logic               pend_v_r;

  op_t         op;
  logic [31:0] pa, pp, pn;
  logic signed [24:0] ma;
  logic signed [18:0] mb;
  logic [6:0]  settle_n;
  logic [3:0]  dwc;

  assign full = (state_r != S_IDLE);
  assign dwc  = (cfg.corner_dwell > 4'(MAX_DWELL)) ? 4'(MAX_DWELL) : cfg.corner_dwell;
  assign settle_n = ((7'(cfg.blank_settle) > 7'(MAX_SETTLE)) ? 7'(MAX_SETTLE)
                                                             : 7'(cfg.blank_settle))
                    + 7'(dwc);

  // operation list of the current vertex
  always_comb begin
    op = '{kind: OP_END, a: P_CUR, p: P_CUR, n: P_CUR, vm: VM_NONE, settle: 1'b0};
    if (vin_r.first_vertex) begin
      if (!vin_r.last_vertex && ph_r == 3'd0) begin
        op.kind = OP_BLANK; op.a = P_NEW; op.settle = 1'b1;
      end
    end else if (seen_r != 2'd0) begin
      case (ph_r)
        3'd0: begin
          if (seen_r == 2'd1) begin
            op.kind = loop_r ? OP_SKIP : OP_VTX;
            op.a    = P_CUR;
          end else begin
            op.kind = OP_VTX; op.a = P_CUR; op.p = P_BEF; op.n = P_NEW; op.vm = VM_CORN;
          end
        end
        3'd1: begin
          op.kind = OP_SEG; op.a = P_CUR; op.n = P_NEW;
        end
        3'd2: begin
          if (vin_r.last_vertex) begin
            op.kind = OP_VTX; op.a = P_NEW;
            if (loop_r) begin
              op.p = P_CUR; op.n = P_START; op.vm = VM_CORN;
            end else begin
              op.vm = VM_ALW;
            end
          end
        end
        3'd3: begin
          if (loop_r) begin
            op.kind = OP_SEG; op.a = P_NEW; op.n = P_START;
          end else begin
            op.kind = OP_BLANK; op.a = P_NEW;
          end
        end
        3'd4: begin
          if (loop_r) begin
            op.kind = OP_VTX; op.a = P_START; op.p = P_NEW; op.vm = VM_CORN;
            op.n = (seen_r == 2'd1) ? P_NEW : P_SEC;
          end
        end
        3'd5: begin
          if (loop_r) begin
            op.kind = OP_BLANK; op.a = P_START;
          end
        end
        default: op.kind = OP_END;
      endcase
    end
  end

  function automatic logic [31:0] pick(input pt_sel_t s, input logic [31:0] c,
                                       input logic [31:0] b, input logic [31:0] w,
                                       input logic [31:0] st, input logic [31:0] sc);
    case (s)
      P_CUR:   return c;
      P_BEF:   return b;
      P_NEW:   return w;
      P_START: return st;
      P_SEC:   return sc;
      default: return c;
    endcase
  endfunction

  assign pa = pick(op.a, cur_r, bef_r, new_r, start_r, sec_r);
  assign pp = pick(op.p, cur_r, bef_r, new_r, start_r, sec_r);
  assign pn = pick(op.n, cur_r, bef_r, new_r, start_r, sec_r);

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_MX: begin
        ma = $signed({1'b0, cfg.scale_x});
        mb = $signed({6'b0, vin_r.vertex_x & CMASK, 1'b1});
      end
      S_MY: begin
        ma = $signed({1'b0, cfg.scale_y});
        mb = $signed({6'b0, vin_r.vertex_y & CMASK, 1'b1});
      end
      S_SQ1: begin
        ma = 25'(sub_r == SUB_COUT ? ox_r : ix_r);
        mb = 19'(sub_r == SUB_COUT ? ox_r : ix_r);
      end
      S_SQ2: begin
        ma = 25'(sub_r == SUB_COUT ? oy_r : iy_r);
        mb = 19'(sub_r == SUB_COUT ? oy_r : iy_r);
      end
      S_D1: begin ma = 25'(ix_r); mb = 19'(ox_r); end
      S_D2: begin ma = 25'(iy_r); mb = 19'(oy_r); end
      S_D3: begin
        ma = $signed({8'b0, il_r});
        mb = $signed({2'b0, root_r});
      end
      S_D4: begin
        ma = 25'(cfg.corner_cosine);
        mb = $signed({1'b0, prod_r[17:0]});
      end
      S_D5: begin
        ma = 25'(cfg.corner_cosine);
        mb = $signed({2'b0, pphi_r});
      end
      S_ST1: begin
        ma = $signed({9'b0, cfg.point_density});
        mb = $signed({2'b0, root_r});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // square root digit step
  logic [20:0] rem_sh, trial;
  logic        sq_ge;
  assign rem_sh = {rem_r[18:0], rad_r[33:32]};
  assign trial  = {2'b0, root_r, 2'b01};
  assign sq_ge  = (rem_sh >= trial);

  // divider step
  logic [4:0] dr_sh;
  logic       dv_ge;
  assign dr_sh = {drem_r[3:0], dnum_r[15]};
  assign dv_ge = (dr_sh >= steps_r);

  // step count and corner test
  logic [33:0]        st_sum;
  logic [11:0]        st_raw;
  logic [4:0]         st_cl;
  logic signed [53:0] lhs, rhs;
  assign st_sum = {1'b0, prod_r[32:0]} + 34'h3FFFFF;
  assign st_raw = st_sum[33:22];
  assign st_cl  = (st_raw == 12'd0) ? 5'd1
                : (st_raw > 12'(MAX_STEPS)) ? 5'(MAX_STEPS) : st_raw[4:0];
  assign lhs = {{18{dot_r[35]}}, dot_r} <<< 15;
  assign rhs = ({{20{prod_r[33]}}, prod_r[33:0]} <<< 18) + {{20{lo_r[33]}}, lo_r};

  always_comb begin
    cmd_push = 1'b0;
    cmd      = pend_r;
    if (state_r == S_EMIT && pend_v_r && !cmd_full) begin
      cmd_push = 1'b1;
    end
    if (state_r == S_FLUSH && pend_v_r && !cmd_full) begin
      cmd_push = 1'b1;
      cmd.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      seen_r   <= '0;
      loop_r   <= 1'b0;
      pend_v_r <= 1'b0;
      start_r  <= '0;
      sec_r    <= '0;
      bef_r    <= '0;
      cur_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (push) begin
            vin_r   <= in_item;
            state_r <= S_MX;
          end
        end
        S_MX: state_r <= S_MY;
        S_MY: begin
          new_r[31:16] <= sat16(prod_r);
          state_r      <= S_SY;
        end
        S_SY: begin
          new_r[15:0] <= sat16(prod_r);
          ph_r        <= '0;
          state_r     <= S_OP;
        end
        S_OP: begin
          case (op.kind)
            OP_SKIP: ph_r <= ph_r + 1'b1;
            OP_BLANK: begin
              if (op.settle && settle_n == 7'd0) begin
                ph_r <= ph_r + 1'b1;
              end else begin
                newc_r  <= mk_rep(pa, 1'b0, op.settle ? settle_n : 7'd1);
                state_r <= S_EMIT;
              end
            end
            OP_VTX: begin
              if (op.vm == VM_CORN) begin
                ix_r    <= dif(pa[31:16], pp[31:16]);
                iy_r    <= dif(pa[15:0], pp[15:0]);
                ox_r    <= dif(pn[31:16], pa[31:16]);
                oy_r    <= dif(pn[15:0], pa[15:0]);
                sub_r   <= SUB_CIN;
                state_r <= S_SQ1;
              end else begin
                newc_r  <= mk_rep(pa, 1'b1,
                                  7'd1 + ((op.vm == VM_ALW) ? 7'(dwc) : 7'd0));
                state_r <= S_EMIT;
              end
            end
            OP_SEG: begin
              ix_r    <= dif(pn[31:16], pa[31:16]);
              iy_r    <= dif(pn[15:0], pa[15:0]);
              sub_r   <= SUB_SEG;
              state_r <= S_SQ1;
            end
            default: state_r <= S_FLUSH;
          endcase
        end
        S_SQ1: state_r <= S_SQ2;
        S_SQ2: begin
          acc_r   <= prod_r[33:0];
          state_r <= S_SQ3;
        end
        S_SQ3: begin
          rad_r   <= acc_r + prod_r[33:0];
          rem_r   <= '0;
          root_r  <= '0;
          it_r    <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          rem_r  <= sq_ge ? rem_sh - trial : rem_sh;
          root_r <= {root_r[15:0], sq_ge};
          rad_r  <= {rad_r[31:0], 2'b00};
          it_r   <= it_r + 1'b1;
          if (it_r == 5'd16) begin
            state_r <= S_LEN;
          end
        end
        S_LEN: begin
          case (sub_r)
            SUB_CIN: begin
              il_r    <= root_r;
              sub_r   <= SUB_COUT;
              state_r <= S_SQ1;
            end
            SUB_COUT: begin
              if (il_r == '0 || root_r == '0) begin
                newc_r  <= mk_rep(pa, 1'b1, 7'd1);
                state_r <= S_EMIT;
              end else begin
                state_r <= S_D1;
              end
            end
            default: state_r <= S_ST1;
          endcase
        end
        S_D1: state_r <= S_D2;
        S_D2: begin
          dot_r   <= prod_r[35:0];
          state_r <= S_D3;
        end
        S_D3: begin
          dot_r   <= dot_r + prod_r[35:0];
          state_r <= S_D4;
        end
        S_D4: begin
          pphi_r  <= prod_r[34:18];
          state_r <= S_D5;
        end
        S_D5: begin
          lo_r    <= prod_r[33:0];
          state_r <= S_D6;
        end
        S_D6: begin
          newc_r  <= mk_rep(pa, 1'b1, 7'd1 + ((lhs < rhs) ? 7'(dwc) : 7'd0));
          state_r <= S_EMIT;
        end
        S_ST1: state_r <= S_ST2;
        S_ST2: begin
          steps_r <= st_cl;
          if (st_cl <= 5'd1) begin
            ph_r    <= ph_r + 1'b1;
            state_r <= S_OP;
          end else begin
            dnum_r  <= mag(ix_r);
            drem_r  <= '0;
            dq_r    <= '0;
            it_r    <= '0;
            dsel_r  <= 1'b0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          drem_r <= dv_ge ? dr_sh - steps_r : dr_sh;
          dq_r   <= {dq_r[14:0], dv_ge};
          dnum_r <= {dnum_r[14:0], 1'b0};
          it_r   <= it_r + 1'b1;
          if (it_r == 5'd15) begin
            if (!dsel_r) begin
              qx_r   <= {dq_r[14:0], dv_ge};
              rx_r   <= dv_ge ? dr_sh - steps_r : dr_sh;
              dnum_r <= mag(iy_r);
              drem_r <= '0;
              dq_r   <= '0;
              it_r   <= '0;
              dsel_r <= 1'b1;
            end else begin
              newc_r       <= '0;
              newc_r.seg   <= 1'b1;
              newc_r.x     <= pa[31:16];
              newc_r.y     <= pa[15:0];
              newc_r.on    <= 1'b1;
              newc_r.neg_x <= ix_r[16];
              newc_r.neg_y <= iy_r[16];
              newc_r.qx    <= qx_r;
              newc_r.rx    <= rx_r;
              newc_r.qy    <= {dq_r[14:0], dv_ge};
              newc_r.ry    <= dv_ge ? dr_sh - steps_r : dr_sh;
              newc_r.steps <= steps_r;
              state_r      <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          // hold back one command so the last one of the vertex gets run_end
          if (!pend_v_r || !cmd_full) begin
            pend_r   <= newc_r;
            pend_v_r <= 1'b1;
            ph_r     <= ph_r + 1'b1;
            state_r  <= S_OP;
          end
        end
        S_FLUSH: begin
          if (!pend_v_r || !cmd_full) begin
            pend_v_r <= 1'b0;
            state_r  <= S_IDLE;
            if (vin_r.first_vertex) begin
              if (vin_r.last_vertex) begin
                seen_r <= 2'd0;
              end else begin
                loop_r  <= vin_r.closed_loop;
                start_r <= new_r;
                cur_r   <= new_r;
                seen_r  <= 2'd1;
              end
            end else if (seen_r != 2'd0) begin
              if (seen_r == 2'd1) begin
                sec_r <= new_r;
              end
              if (vin_r.last_vertex) begin
                seen_r <= 2'd0;
              end else begin
                bef_r <= cur_r;
                cur_r <= new_r;
                if (seen_r != 2'd3) begin
                  seen_r <= seen_r + 1'b1;
                end
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/lvp_back.sv -----
// ----------------------------------------------------------------------------
// lvp_back
// Point emitter: expands queued commands into beam points through an output
// register; it takes a command once the last is done, and waits on pop.
// ----------------------------------------------------------------------------
module lvp_back
  import lvp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  output out_item_t out_item,
  output logic      empty,
  input  logic      pop
);

  logic        act_r, ov_r;
  cmd_t        c_r;
  logic [6:0]  i_r;
  logic [15:0] qa_x_r, qa_y_r;
  logic [4:0]  ra_x_r, ra_y_r;
  out_item_t   o_r;

  logic        adv, fin;
  logic [4:0]  rs_x, rs_y;
  logic [15:0] px, py;

  assign adv      = !ov_r || pop;
  assign cmd_pop  = !act_r && !cmd_empty;
  assign empty    = !ov_r;
  assign out_item = o_r;

  assign fin  = c_r.seg ? (i_r == 7'(c_r.steps) - 7'd1) : (i_r == 7'd1);
  assign rs_x = ra_x_r + c_r.rx;
  assign rs_y = ra_y_r + c_r.ry;
  assign px   = !c_r.seg ? c_r.x : (c_r.neg_x ? c_r.x - qa_x_r : c_r.x + qa_x_r);
  assign py   = !c_r.seg ? c_r.y : (c_r.neg_y ? c_r.y - qa_y_r : c_r.y + qa_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      if (pop && ov_r) begin
        ov_r <= 1'b0;
      end
      if (act_r && adv) begin
        ov_r             <= 1'b1;
        o_r.point_x      <= px;
        o_r.point_y      <= py;
        o_r.beam_on      <= c_r.on;
        o_r.run_end      <= fin && c_r.last;
        if (fin) begin
          act_r <= 1'b0;
        end
        if (c_r.seg) begin
          i_r <= i_r + 1'b1;
          if (rs_x >= c_r.steps) begin
            ra_x_r <= rs_x - c_r.steps;
            qa_x_r <= qa_x_r + c_r.qx + 16'd1;
          end else begin
            ra_x_r <= rs_x;
            qa_x_r <= qa_x_r + c_r.qx;
          end
          if (rs_y >= c_r.steps) begin
            ra_y_r <= rs_y - c_r.steps;
            qa_y_r <= qa_y_r + c_r.qy + 16'd1;
          end else begin
            ra_y_r <= rs_y;
            qa_y_r <= qa_y_r + c_r.qy;
          end
        end else begin
          i_r <= i_r - 1'b1;
        end
      end else if (cmd_pop) begin
        act_r  <= 1'b1;
        c_r    <= cmd;
        i_r    <= cmd.seg ? 7'd1 : cmd.cnt;
        qa_x_r <= cmd.qx;
        qa_y_r <= cmd.qy;
        ra_x_r <= cmd.rx;
        ra_y_r <= cmd.ry;
      end
    end
  end

  a_seg_index: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r && c_r.seg) |-> (i_r != 7'd0 && i_r < 7'(c_r.steps)))
    else $error("segment index out of range");

  a_rep_count: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r && !c_r.seg) |-> (i_r != 7'd0))
    else $error("empty point run in emitter");

endmodule

// ----- design/laser_vector_point_generator_core.sv -----
// ----------------------------------------------------------------------------
// laser_vector_point_generator_core
// Turns contour vertices into a stream of lit and blanked beam points.
// ----------------------------------------------------------------------------
// Input: write a vertex with push while full is low. full stays high while
// the sequencer works on that vertex, longest for the closing vertex of a
// loop. Each length comes from a bit-serial square root; each corner takes
// two lengths and the multiply steps of the corner test, each segment one
// length and a serial divide of dx and dy by the step count.
// Output: points wait in an output register; while empty is low the oldest
// point is on out_item and pop takes it. Points come from a 4-entry
// command queue, so the emitter keeps running while the sequencer works on
// the next vertex; it takes the next command once the current one is done.
// run_end marks the last point of each vertex. A stalled receiver backs up
// the queue and then holds full high.
// Configuration: cfg_valid/cfg_ready (always ready), index and data; write
// only while idle. Reset (rst_n low, synchronous) loads register defaults
// and closes any open contour.
// ----------------------------------------------------------------------------
module laser_vector_point_generator_core
  import lvp_pkg::*;
#(
  parameter int MAX_STEPS  = DEF_MAX_STEPS,
  parameter int MAX_DWELL  = DEF_MAX_DWELL,
  parameter int MAX_SETTLE = DEF_MAX_SETTLE,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             in_item,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t cfg_r;
  cmd_t q_wr, q_rd;
  logic q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blank_settle  <= 5'd4;
      cfg_r.corner_dwell  <= 4'd2;
      cfg_r.point_density <= 16'd25600;
      cfg_r.corner_cosine <= 16'sd16384;
      cfg_r.scale_x       <= 24'd4096;
      cfg_r.scale_y       <= 24'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BLANK_SETTLE:  cfg_r.blank_settle  <= cfg_data[4:0];
        REG_CORNER_DWELL:  cfg_r.corner_dwell  <= cfg_data[3:0];
        REG_POINT_DENSITY: cfg_r.point_density <= cfg_data[15:0];
        REG_CORNER_COSINE: cfg_r.corner_cosine <= $signed(cfg_data[15:0]);
        REG_SCALE_X:       cfg_r.scale_x       <= cfg_data;
        REG_SCALE_Y:       cfg_r.scale_y       <= cfg_data;
        default: ;
      endcase
    end
  end

  lvp_front #(
    .MAX_STEPS  (MAX_STEPS),
    .MAX_DWELL  (MAX_DWELL),
    .MAX_SETTLE (MAX_SETTLE),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .cfg      (cfg_r),
    .cmd_push (q_push),
    .cmd      (q_wr),
    .cmd_full (q_full)
  );

  lvp_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  lvp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_rd),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .out_item  (out_item),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ----- tb/sv/tb_laser_vector_point_generator_core.sv -----
// ----------------------------------------------------------------------------
// tb_laser_vector_point_generator_core
// Self-checking bench for the laser vector point generator. Vertex items are
// pushed under random idling, every point popped is compared against a
// behavioral point predictor, and the register set is swept through several
// settings between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_laser_vector_point_generator_core;
  import lvp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk;
  logic                 rst_n;
  logic                 push;
  logic                 full;
  in_item_t             in_item;
  logic                 empty;
  logic                 pop;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  laser_vector_point_generator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  localparam int MAX_DWELL_C  = DEF_MAX_DWELL;
  localparam int MAX_SETTLE_C = DEF_MAX_SETTLE;
  localparam int MAX_STEPS_C  = DEF_MAX_STEPS;

  // predictor copy of the registers and contour state
  logic [4:0]         p_settle;
  logic [3:0]         p_dwell;
  logic [15:0]        p_density;
  logic signed [15:0] p_cosine;
  logic [23:0]        p_scale_x;
  logic [23:0]        p_scale_y;
  longint             c_start_x, c_start_y, c_second_x, c_second_y;
  longint             c_prev_x, c_prev_y, c_cur_x, c_cur_y;
  int                 c_seen;
  bit                 c_loop;

  out_item_t expected_points[$];
  int        errors;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_cycles;

  function automatic longint to_units(logic [11:0] p, logic [23:0] s);
    longint v;
    v = ((2 * longint'(p) + 1) * longint'(s) + 256) >>> 9;
    return (v > 65535) ? 65535 : v;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint seg_len(longint dx, longint dy);
    return int_sqrt(longint'(dx * dx + dy * dy));
  endfunction

  function automatic bit sharp_turn(longint ax, longint ay, longint px, longint py,
                                    longint nx, longint ny);
    longint il, ol, dot;
    il = seg_len(ax - px, ay - py);
    ol = seg_len(nx - ax, ny - ay);
    if (il == 0 || ol == 0) return 1'b0;
    dot = (ax - px) * (nx - ax) + (ay - py) * (ny - ay);
    return (dot * 32768) < (longint'(p_cosine) * il * ol);
  endfunction

  function automatic int dwell_reps();
    return (p_dwell > MAX_DWELL_C) ? MAX_DWELL_C : int'(p_dwell);
  endfunction

  function automatic void add_point(longint x, longint y, bit on);
    out_item_t pt;
    pt.point_x = x[15:0];
    pt.point_y = y[15:0];
    pt.beam_on = on;
    pt.run_end = 1'b0;
    expected_points = {expected_points, pt};
  endfunction

  function automatic void add_vertex(longint x, longint y, bit dw);
    int k;
    add_point(x, y, 1'b1);
    if (dw) for (k = 0; k < dwell_reps(); k++) add_point(x, y, 1'b1);
  endfunction

  function automatic void add_segment(longint ax, longint ay, longint bx, longint by);
    longint dx, dy, steps, i;
    dx = bx - ax;
    dy = by - ay;
    steps = (seg_len(dx, dy) * longint'(p_density) + ((64'd1 << 22) - 1)) >>> 22;
    if (steps < 1) steps = 1;
    if (steps > MAX_STEPS_C) steps = MAX_STEPS_C;
    for (i = 1; i < steps; i++) add_point(ax + dx * i / steps, ay + dy * i / steps, 1'b1);
  endfunction

  function automatic void predict_vertex(in_item_t it);
    longint px, py;
    int base, k, n;
    base = expected_points.size();
    px = to_units(it.vertex_x, p_scale_x);
    py = to_units(it.vertex_y, p_scale_y);
    if (it.first_vertex) begin
      c_seen = 0;
      if (!it.last_vertex) begin
        c_loop = it.closed_loop;
        c_start_x = px; c_start_y = py;
        c_cur_x = px; c_cur_y = py;
        c_seen = 1;
        n = ((p_settle > MAX_SETTLE_C) ? MAX_SETTLE_C : int'(p_settle)) + dwell_reps();
        for (k = 0; k < n; k++) add_point(px, py, 1'b0);
      end
    end else if (c_seen != 0) begin
      if (c_seen == 1) begin
        c_second_x = px; c_second_y = py;
        if (!c_loop) add_vertex(c_cur_x, c_cur_y, 1'b0);
      end else begin
        add_vertex(c_cur_x, c_cur_y,
                   sharp_turn(c_cur_x, c_cur_y, c_prev_x, c_prev_y, px, py));
      end
      add_segment(c_cur_x, c_cur_y, px, py);
      if (it.last_vertex) begin
        if (c_loop) begin
          add_vertex(px, py, sharp_turn(px, py, c_cur_x, c_cur_y, c_start_x, c_start_y));
          add_segment(px, py, c_start_x, c_start_y);
          add_vertex(c_start_x, c_start_y,
                     sharp_turn(c_start_x, c_start_y, px, py, c_second_x, c_second_y));
          add_point(c_start_x, c_start_y, 1'b0);
        end else begin
          add_vertex(px, py, 1'b1);
          add_point(px, py, 1'b0);
        end
        c_seen = 0;
      end else begin
        c_prev_x = c_cur_x; c_prev_y = c_cur_y;
        c_cur_x = px; c_cur_y = py;
        if (c_seen < 3) c_seen++;
      end
    end
    if (expected_points.size() > base)
      expected_points[expected_points.size() - 1].run_end = 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t exp_pt;
    if (rst_n && pop && !empty) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point, expected none, actual %h", $time, out_item);
        errors++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (out_item.point_x !== exp_pt.point_x)
          $display("%0t: point_x expected %h actual %h", $time, exp_pt.point_x,
                   out_item.point_x);
        if (out_item.point_y !== exp_pt.point_y)
          $display("%0t: point_y expected %h actual %h", $time, exp_pt.point_y,
                   out_item.point_y);
        if (out_item.beam_on !== exp_pt.beam_on)
          $display("%0t: beam_on expected %b actual %b", $time, exp_pt.beam_on,
                   out_item.beam_on);
        if (out_item.run_end !== exp_pt.run_end)
          $display("%0t: run_end expected %b actual %b", $time, exp_pt.run_end,
                   out_item.run_end);
        if (out_item !== exp_pt) errors++;
      end
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_vertex(logic [11:0] x, logic [11:0] y, bit f, bit l, bit c);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    push = 1'b1;
    in_item = '{vertex_x: x, vertex_y: y, first_vertex: f, last_vertex: l, closed_loop: c};
    @(posedge clk);
    while (full) @(posedge clk);
    predict_vertex(in_item);
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_points.size() != 0 || full) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BLANK_SETTLE:  p_settle  = val[4:0];
      REG_CORNER_DWELL:  p_dwell   = val[3:0];
      REG_POINT_DENSITY: p_density = val[15:0];
      REG_CORNER_COSINE: p_cosine  = val[15:0];
      REG_SCALE_X:       p_scale_x = val;
      REG_SCALE_Y:       p_scale_y = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(int settle, int dwell, int dens, int cosv, int sx, int sy);
    wait_idle();
    write_reg(REG_BLANK_SETTLE, 24'(settle));
    write_reg(REG_CORNER_DWELL, 24'(dwell));
    write_reg(REG_POINT_DENSITY, 24'(dens));
    write_reg(REG_CORNER_COSINE, 24'(cosv & 16'hFFFF));
    write_reg(REG_SCALE_X, 24'(sx));
    write_reg(REG_SCALE_Y, 24'(sy));
  endtask

  task automatic test_directed();
    send_vertex(12'd5, 12'd5, 0, 0, 0);              // ignored while idle
    send_vertex(12'd7, 12'd9, 1, 1, 1);              // single vertex contour
    send_vertex(12'd0, 12'd0, 1, 0, 0);              // open contour, extremes
    send_vertex(12'd4095, 12'd0, 0, 0, 0);
    send_vertex(12'd4095, 12'd4095, 0, 0, 0);
    send_vertex(12'd0, 12'd4095, 0, 1, 0);
    send_vertex(12'd100, 12'd100, 1, 0, 1);          // closed square
    send_vertex(12'd200, 12'd100, 0, 0, 0);
    send_vertex(12'd200, 12'd200, 0, 0, 0);
    send_vertex(12'd100, 12'd200, 0, 1, 0);
    send_vertex(12'd10, 12'd10, 1, 0, 0);            // restart mid-contour
    send_vertex(12'd20, 12'd10, 0, 0, 0);
    send_vertex(12'd50, 12'd50, 1, 0, 1);
    send_vertex(12'd50, 12'd50, 0, 0, 0);            // zero-length segment
    send_vertex(12'd60, 12'd40, 0, 1, 0);
    send_vertex(12'd3000, 12'd1, 1, 0, 0);           // two-vertex open
    send_vertex(12'd1, 12'd3000, 0, 1, 0);
  endtask

  task automatic test_random(int n_items);
    int sent, len, k;
    bit c;
    logic [11:0] x, y;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_vertex(12'($urandom), 12'($urandom), 1'($urandom), 1'($urandom),
                    1'($urandom));  // noise
        sent++;
      end else begin
        len = $urandom_range(2, 6);
        c = 1'($urandom);
        x = 12'($urandom);
        y = 12'($urandom);
        send_vertex(x, y, 1, 0, c);
        for (k = 1; k < len && !($urandom_range(19) == 0); k++) begin
          if ($urandom_range(1)) begin
            x = 12'($urandom);
            y = 12'($urandom);
          end else begin
            x = 12'(x + $urandom_range(0, 60) - 30);
            y = 12'(y + $urandom_range(0, 60) - 30);
          end
          send_vertex(x, y, 0, k == len - 1, 1'($urandom));
        end
        sent += len;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 600;
    test_random(12);
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_item = '0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    hold_cycles = 0;
    send_idle_pct = 23;
    recv_idle_pct = 45;
    p_settle = 5'd4; p_dwell = 4'd2; p_density = 16'd25600; p_cosine = 16'sd16384;
    p_scale_x = 24'd4096; p_scale_y = 24'd4096;
    c_seen = 0; c_loop = 0;
    c_start_x = 0; c_start_y = 0; c_second_x = 0; c_second_y = 0;
    c_prev_x = 0; c_prev_y = 0; c_cur_x = 0; c_cur_y = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(60);
    set_regs(0, 0, 256, -32768, 1, 1);
    test_directed();
    test_random(40);
    send_idle_pct = 45;
    recv_idle_pct = 23;
    set_regs(31, 15, 65535, 32767, 24'hFFFFFF, 24'hFFFFFF);
    test_random(40);
    set_regs(24, 8, 60000, 0, 12000, 9000);
    test_backpressure();
    test_random(50);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(3, 1, 40000, -20000, 8192, 6000);
    test_random(60);
    set_regs(4, 2, 25600, 16384, 4096, 4096);
    test_random(40);

    while (expected_points.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lvp_pkg.sv
design/lvp_fifo.sv
design/lvp_front.sv
design/lvp_back.sv
design/laser_vector_point_generator_core.sv
tb/sv/tb_laser_vector_point_generator_core.sv
